>>> hdl/bcc_pkg.sv
package bcc_pkg;

   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic [7:0] CHAR_FF      = 8'o014;
   localparam logic [7:0] CHAR_SQ      = 8'o047;
   localparam logic [7:0] CHAR_DQ      = 8'o042;
   localparam logic [7:0] CHAR_NL      = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_STAR    = 8'h2A;
   localparam logic [7:0] CHAR_SLASH   = 8'h2F;
   localparam logic [7:0] CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0] CHAR_LPAREN  = 8'h28;
   localparam logic [7:0] CHAR_LSQUARE = 8'h5B;
   localparam logic [7:0] CHAR_RBRACE  = 8'h7D;
   localparam logic [7:0] CHAR_RPAREN  = 8'h29;
   localparam logic [7:0] CHAR_RSQUARE = 8'h5D;

   localparam logic [1:0] KIND_BRACE  = 2'd0;
   localparam logic [1:0] KIND_PAREN  = 2'd1;
   localparam logic [1:0] KIND_SQUARE = 2'd2;

   typedef enum logic [3:0] {
      VERDICT_RUNNING  = 4'd0,
      VERDICT_PASS     = 4'd1,
      VERDICT_QUOTE    = 4'd2,
      VERDICT_COMMENT  = 4'd3,
      VERDICT_EOF      = 4'd4,
      VERDICT_PAGE     = 4'd5,
      VERDICT_MISMATCH = 4'd6,
      VERDICT_STRAY_CE = 4'd7,
      VERDICT_STRAY_CL = 4'd8,
      VERDICT_OVERFLOW = 4'd9,
      VERDICT_STOPPED  = 4'd10
   } verdict_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_op_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stack_status_type;

   function automatic logic is_opener(input logic [7:0] b);
      return (b == CHAR_LBRACE) || (b == CHAR_LPAREN) || (b == CHAR_LSQUARE);
   endfunction

   function automatic logic is_closer(input logic [7:0] b);
      return (b == CHAR_RBRACE) || (b == CHAR_RPAREN) || (b == CHAR_RSQUARE);
   endfunction

   function automatic logic [1:0] bracket_kind(input logic [7:0] b);
      logic [1:0] k;
      k = KIND_BRACE;
      if ((b == CHAR_LPAREN) || (b == CHAR_RPAREN)) begin
         k = KIND_PAREN;
      end else if ((b == CHAR_LSQUARE) || (b == CHAR_RSQUARE)) begin
         k = KIND_SQUARE;
      end
      return k;
   endfunction

   function automatic logic [7:0] opener_char(input logic [1:0] k);
      logic [7:0] c;
      unique case (k)
         KIND_PAREN:  c = CHAR_LPAREN;
         KIND_SQUARE: c = CHAR_LSQUARE;
         default:     c = CHAR_LBRACE;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/bcc_cell.sv
module bcc_cell #(
   parameter int ENTRY_WIDTH = 2 + 2 * bcc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  bcc_pkg::stack_op_type    op,
   input  logic [ENTRY_WIDTH-1:0]   from_above,
   input  logic [ENTRY_WIDTH-1:0]   from_below,
   output logic [ENTRY_WIDTH-1:0]   entry_ff
);

   always_ff @(posedge clock) begin
      if (op.push) begin
         entry_ff <= from_above;
      end else if (op.pop) begin
         entry_ff <= from_below;
      end
   end

endmodule

>>> hdl/bcc_stack.sv
module bcc_stack #(
   parameter int STACK_DEPTH = bcc_pkg::STACK_DEPTH_DEFAULT,
   parameter int ENTRY_WIDTH = 2 + 2 * bcc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bcc_pkg::stack_op_type       op,
   input  logic [ENTRY_WIDTH-1:0]      push_entry,
   output logic [ENTRY_WIDTH-1:0]      top_entry,
   output bcc_pkg::stack_status_type   status
);

   localparam int DEPTH_WIDTH = $clog2(STACK_DEPTH + 1);

   logic [DEPTH_WIDTH-1:0] depth_ff;
   logic [DEPTH_WIDTH-1:0] depth_in;
   logic [ENTRY_WIDTH-1:0] entries [STACK_DEPTH];

   // top of stack always sits in cell 0; push shifts down, pop shifts up
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] above;
      logic [ENTRY_WIDTH-1:0] below;
      if (i == 0) begin : g_first
         assign above = push_entry;
      end else begin : g_mid_above
         assign above = entries[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = entries[i];
      end else begin : g_mid_below
         assign below = entries[i+1];
      end
      bcc_cell #(
         .ENTRY_WIDTH (ENTRY_WIDTH)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .from_above (above),
         .from_below (below),
         .entry_ff   (entries[i])
      );
   end

   always_comb begin
      depth_in = depth_ff;
      if (op.push) begin
         depth_in = depth_ff + DEPTH_WIDTH'(1);
      end else if (op.pop) begin
         depth_in = depth_ff - DEPTH_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign top_entry    = entries[0];
   assign status.empty = (depth_ff == '0);
   assign status.full  = (depth_ff == DEPTH_WIDTH'(STACK_DEPTH));

endmodule

>>> hdl/c_source_bracket_comment_checker.sv
// Checks C source for balanced (), {} and [] and for well-formed block comments
// and quotes. Send one source byte per item, then an item with req_end_of_file
// set; every item gives exactly one result, verdict 0 while scanning and the
// first error (or pass at end of file) after which every item reports stopped
// until reset. Throughput is one item per cycle while rsp_ready stays high: the
// scanner decides each byte combinationally and the opener stack is a row of
// shift cells, so a push or pop finishes in the same cycle as its byte. The
// rsp_ register decouples the two sides, and an item is taken whenever that
// register is empty or being read. csr_write_data sets page mode, in which
// brackets and comments must also be closed at every form feed.
module c_source_bracket_comment_checker #(
   parameter int STACK_DEPTH = bcc_pkg::STACK_DEPTH_DEFAULT,
   parameter int COUNT_WIDTH = bcc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_file,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_verdict,
   output logic [7:0]  rsp_report_char,
   output logic [15:0] rsp_report_line,
   output logic [15:0] rsp_report_page,
   output logic [7:0]  rsp_found_char,
   output logic [15:0] rsp_found_line,
   output logic [15:0] rsp_found_page,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);

   localparam int ENTRY_WIDTH = 2 + 2 * COUNT_WIDTH;

   logic accept;

   logic                   page_mode_ff;
   logic [COUNT_WIDTH-1:0] line_ff, line_in;
   logic [COUNT_WIDTH-1:0] page_ff, page_in;
   logic                   in_comment_ff, in_comment_in;
   logic [COUNT_WIDTH-1:0] cmt_line_ff, cmt_line_in;
   logic [COUNT_WIDTH-1:0] cmt_page_ff, cmt_page_in;
   logic                   in_quote_ff, in_quote_in;
   logic                   quote_dq_ff, quote_dq_in;
   logic                   after_slash_ff, after_slash_in;
   logic                   after_star_ff, after_star_in;
   logic                   finished_ff, finished_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   bcc_pkg::verdict_type      verdict_ff, verdict_in;
   logic [7:0]                rchar_ff, rchar_in;
   logic [15:0]               rline_ff, rline_in;
   logic [15:0]               rpage_ff, rpage_in;
   logic [7:0]                fchar_ff, fchar_in;
   logic [15:0]               fline_ff, fline_in;
   logic [15:0]               fpage_ff, fpage_in;

   bcc_pkg::stack_op_type     op_req;
   bcc_pkg::stack_op_type     op;
   bcc_pkg::stack_status_type status;
   logic [ENTRY_WIDTH-1:0]    push_entry;
   logic [ENTRY_WIDTH-1:0]    top_entry;
   logic [1:0]                top_kind;
   logic [COUNT_WIDTH-1:0]    top_line;
   logic [COUNT_WIDTH-1:0]    top_page;

   logic [7:0] b;
   logic [7:0] qc;
   logic       proceed;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign top_kind = top_entry[ENTRY_WIDTH-1 -: 2];
   assign top_line = top_entry[2*COUNT_WIDTH-1:COUNT_WIDTH];
   assign top_page = top_entry[COUNT_WIDTH-1:0];

   assign push_entry = {bcc_pkg::bracket_kind(req_source_byte), line_ff, page_ff};
   assign op.push    = accept && op_req.push;
   assign op.pop     = accept && op_req.pop;

   bcc_stack #(
      .STACK_DEPTH (STACK_DEPTH),
      .ENTRY_WIDTH (ENTRY_WIDTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .push_entry (push_entry),
      .top_entry  (top_entry),
      .status     (status)
   );

   always_comb begin
      b  = req_source_byte;
      qc = quote_dq_ff ? bcc_pkg::CHAR_DQ : bcc_pkg::CHAR_SQ;

      line_in        = line_ff;
      page_in        = page_ff;
      in_comment_in  = in_comment_ff;
      cmt_line_in    = cmt_line_ff;
      cmt_page_in    = cmt_page_ff;
      in_quote_in    = in_quote_ff;
      quote_dq_in    = quote_dq_ff;
      after_slash_in = after_slash_ff;
      after_star_in  = after_star_ff;
      op_req         = '0;

      verdict_in = bcc_pkg::VERDICT_RUNNING;
      rchar_in   = '0;
      rline_in   = '0;
      rpage_in   = '0;
      fchar_in   = '0;
      fline_in   = '0;
      fpage_in   = '0;
      proceed    = 1'b0;

      priority if (finished_ff) begin
         verdict_in = bcc_pkg::VERDICT_STOPPED;
      end else if (req_end_of_file) begin
         after_slash_in = 1'b0;
         after_star_in  = 1'b0;
         priority if (in_quote_ff) begin
            verdict_in = bcc_pkg::VERDICT_QUOTE;
            rchar_in   = qc;
            rline_in   = 16'(line_ff);
            rpage_in   = 16'(page_ff);
         end else if (in_comment_ff) begin
            verdict_in = bcc_pkg::VERDICT_COMMENT;
            rline_in   = 16'(cmt_line_ff);
            rpage_in   = 16'(cmt_page_ff);
         end else if (!status.empty) begin
            verdict_in = bcc_pkg::VERDICT_EOF;
            rchar_in   = bcc_pkg::opener_char(top_kind);
            rline_in   = 16'(top_line);
            rpage_in   = 16'(top_page);
         end else begin
            verdict_in = bcc_pkg::VERDICT_PASS;
         end
      end else if (in_quote_ff) begin
         priority if (b == qc) begin
            in_quote_in = 1'b0;
         end else if (b == bcc_pkg::CHAR_NL) begin
            verdict_in = bcc_pkg::VERDICT_QUOTE;
            rchar_in   = qc;
            rline_in   = 16'(line_ff);
            rpage_in   = 16'(page_ff);
         end else begin
         end
      end else begin
         proceed = 1'b1;
         if (after_slash_ff) begin
            after_slash_in = 1'b0;
            if (b == bcc_pkg::CHAR_STAR) begin
               in_comment_in = 1'b1;
               cmt_line_in   = line_ff;
               cmt_page_in   = page_ff;
               proceed       = 1'b0;
            end
         end else if (after_star_ff) begin
            after_star_in = 1'b0;
            if (b == bcc_pkg::CHAR_SLASH) begin
               proceed = 1'b0;
               if (!in_comment_ff) begin
                  verdict_in = bcc_pkg::VERDICT_STRAY_CE;
                  rline_in   = 16'(line_ff);
                  rpage_in   = 16'(page_ff);
               end else begin
                  in_comment_in = 1'b0;
               end
            end
         end
      end

      if (proceed) begin
         priority if (b == bcc_pkg::CHAR_NL) begin
            line_in = (&line_ff) ? line_ff : line_ff + COUNT_WIDTH'(1);
         end else if (b == bcc_pkg::CHAR_FF) begin
            page_in = (&page_ff) ? page_ff : page_ff + COUNT_WIDTH'(1);
            line_in = '0;
            if (page_mode_ff) begin
               if (in_comment_ff) begin
                  verdict_in = bcc_pkg::VERDICT_COMMENT;
                  rline_in   = 16'(cmt_line_ff);
                  rpage_in   = 16'(cmt_page_ff);
               end else if (!status.empty) begin
                  verdict_in = bcc_pkg::VERDICT_PAGE;
                  rchar_in   = bcc_pkg::opener_char(top_kind);
                  rline_in   = 16'(top_line);
                  rpage_in   = 16'(top_page);
               end
            end
         end else if ((b == bcc_pkg::CHAR_SQ) || (b == bcc_pkg::CHAR_DQ)) begin
            if (!in_comment_ff) begin
               in_quote_in = 1'b1;
               quote_dq_in = (b == bcc_pkg::CHAR_DQ);
            end
         end else if (b == bcc_pkg::CHAR_SPACE) begin
         end else if (in_comment_ff) begin
            if (b == bcc_pkg::CHAR_STAR) begin
               after_star_in = 1'b1;
            end
         end else if (bcc_pkg::is_opener(b)) begin
            if (status.full) begin
               verdict_in = bcc_pkg::VERDICT_OVERFLOW;
               rchar_in   = b;
               rline_in   = 16'(line_ff);
               rpage_in   = 16'(page_ff);
            end else begin
               op_req.push = 1'b1;
            end
         end else if (bcc_pkg::is_closer(b)) begin
            priority if (status.empty) begin
               verdict_in = bcc_pkg::VERDICT_STRAY_CL;
               rchar_in   = b;
               rline_in   = 16'(line_ff);
               rpage_in   = 16'(page_ff);
            end else if (top_kind != bcc_pkg::bracket_kind(b)) begin
               verdict_in = bcc_pkg::VERDICT_MISMATCH;
               rchar_in   = bcc_pkg::opener_char(top_kind);
               rline_in   = 16'(top_line);
               rpage_in   = 16'(top_page);
               fchar_in   = b;
               fline_in   = 16'(line_ff);
               fpage_in   = 16'(page_ff);
            end else begin
               op_req.pop = 1'b1;
            end
         end else if (b == bcc_pkg::CHAR_SLASH) begin
            after_slash_in = 1'b1;
         end else if (b == bcc_pkg::CHAR_STAR) begin
            after_star_in = 1'b1;
         end else begin
         end
      end

      finished_in = finished_ff || ((verdict_in != bcc_pkg::VERDICT_RUNNING) &&
                                    (verdict_in != bcc_pkg::VERDICT_STOPPED));

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_mode_ff   <= 1'b0;
         line_ff        <= '0;
         page_ff        <= COUNT_WIDTH'(1);
         in_comment_ff  <= 1'b0;
         cmt_line_ff    <= '0;
         cmt_page_ff    <= COUNT_WIDTH'(1);
         in_quote_ff    <= 1'b0;
         quote_dq_ff    <= 1'b0;
         after_slash_ff <= 1'b0;
         after_star_ff  <= 1'b0;
         finished_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            page_mode_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            line_ff        <= line_in;
            page_ff        <= page_in;
            in_comment_ff  <= in_comment_in;
            cmt_line_ff    <= cmt_line_in;
            cmt_page_ff    <= cmt_page_in;
            in_quote_ff    <= in_quote_in;
            quote_dq_ff    <= quote_dq_in;
            after_slash_ff <= after_slash_in;
            after_star_ff  <= after_star_in;
            finished_ff    <= finished_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         verdict_ff <= verdict_in;
         rchar_ff   <= rchar_in;
         rline_ff   <= rline_in;
         rpage_ff   <= rpage_in;
         fchar_ff   <= fchar_in;
         fline_ff   <= fline_in;
         fpage_ff   <= fpage_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_report_char = rchar_ff;
   assign rsp_report_line = rline_ff;
   assign rsp_report_page = rpage_ff;
   assign rsp_found_char  = fchar_ff;
   assign rsp_found_line  = fline_ff;
   assign rsp_found_page  = fpage_ff;

endmodule
